// ----- hdl/dnd_pkg.sv -----
// ----------------------------------------------------------------------------
// dnd_pkg
// Shared types and constants of the DNS name decompressor.
// ----------------------------------------------------------------------------
package dnd_pkg;

    // Message memory size. It must be a power of two so that addresses wrap.
    localparam int MEM_DEPTH       = 1024;
    localparam int ADDR_W          = $clog2(MEM_DEPTH);
    localparam int MAX_NAME_LENGTH = 255;
    localparam int MAX_HOPS        = 16;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef enum logic
    {
        MODE_LOAD   = 1'b0,
        MODE_DECODE = 1'b1
    } dnd_mode_t;

    typedef enum logic [1:0]
    {
        ERR_NONE = 2'd0,
        ERR_HOPS = 2'd1,
        ERR_LONG = 2'd2
    } dnd_err_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LEN,
        ST_PTR,
        ST_DOT,
        ST_CHR,
        ST_FIN
    } dnd_state_t;

    // Input item.
    typedef struct packed
    {
        logic       mode;
        logic [9:0] address;
        logic [7:0] data_byte;
    } dnd_in_t;

    // Result item.
    typedef struct packed
    {
        logic [31:0] name_chars;
        logic [2:0]  char_count;
        logic        last;
        logic [8:0]  octets_consumed;
        logic [1:0]  error;
    } dnd_out_t;

    // Request from the walker to the packer: one character or the closing result.
    typedef struct packed
    {
        logic       push;
        logic       fin;
        logic [7:0] ch;
        logic [8:0] octets;
        dnd_err_t   err;
    } dnd_push_t;

endpackage

// ----- hdl/dns_name_decompressor.sv -----
// ----------------------------------------------------------------------------
// dns_name_decompressor
// Message byte store with a name walker that expands compressed DNS names.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  --------+------------------------+---------------------------------------
//  cmd     | cmd_valid / cmd_ready  | dnd_in_t: mode, address, data_byte
//  res     | res_valid / res_ready  | dnd_out_t: name_chars, char_count,
//          |                        |   last, octets_consumed, error
//
// A load item is written while idle. A decode item walks each message byte,
// pointer bytes included, pushes a dot between labels and the closing
// result, and goes back to idle before the next item is taken; the single
// read port of the message memory reads one byte at a time. cmd_ready is
// low for the whole decode.
// Reset clears the control state only; the message memory holds no reset
// and needs no clearing pass. A stalled res channel holds the walker.
// ----------------------------------------------------------------------------
module dns_name_decompressor (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  dnd_pkg::dnd_in_t  cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output dnd_pkg::dnd_out_t res
);

    logic                       ram_we;
    logic [dnd_pkg::ADDR_W-1:0] ram_waddr;
    logic [7:0]                 ram_wdata;
    logic [dnd_pkg::ADDR_W-1:0] ram_raddr;
    logic [7:0]                 ram_rdata;
    dnd_pkg::dnd_push_t         push;
    logic                       push_ready;

    // Message memory.
    dnd_ram #(
        .WIDTH (8),
        .DEPTH (dnd_pkg::MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Name walk sequencer.
    dnd_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .push       (push),
        .push_ready (push_ready)
    );

    // Character packing and result register.
    dnd_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule

// ----- hdl/dnd_ram.sv -----
// ----------------------------------------------------------------------------
// dnd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/dnd_packer.sv -----
// ----------------------------------------------------------------------------
// dnd_packer
// Packs name characters four to a result and holds the result register.
// ----------------------------------------------------------------------------
module dnd_packer (
    input  logic              clk,
    input  logic              rst_n,
    input  dnd_pkg::dnd_push_t push,
    output logic              push_ready,
    output logic              res_valid,
    input  logic              res_ready,
    output dnd_pkg::dnd_out_t res
);

    logic [31:0]       pack_reg, pack_next;
    logic [1:0]        fill_reg, fill_next;
    dnd_pkg::dnd_out_t res_reg, res_next;
    logic              res_valid_reg, res_valid_next;
    logic              slot_free;
    logic              accept;
    logic [31:0]       placed;

    // The result register can take a new result when empty or being drained.
    assign slot_free  = !res_valid_reg || res_ready;
    assign push_ready = push.fin ? slot_free : ((fill_reg != 2'd3) || slot_free);
    assign accept     = push.push && push_ready;

    // Place the character at the byte lane given by the fill count.
    always_comb
    begin
        placed = '0;
        unique case (fill_reg)
            2'd0: placed[7:0]   = push.ch;
            2'd1: placed[15:8]  = push.ch;
            2'd2: placed[23:16] = push.ch;
            2'd3: placed[31:24] = push.ch;
            default: placed = '0;
        endcase
    end

    // Next values of packing and result registers.
    always_comb
    begin
        pack_next      = pack_reg;
        fill_next      = fill_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (accept)
        begin
            if (push.fin)
            begin
                res_next.name_chars      = pack_reg;
                res_next.char_count      = {1'b0, fill_reg};
                res_next.last            = 1'b1;
                res_next.octets_consumed = push.octets;
                res_next.error           = push.err;
                res_valid_next           = 1'b1;
                pack_next                = '0;
                fill_next                = '0;
            end
            else if (fill_reg == 2'd3)
            begin
                res_next.name_chars      = pack_reg | placed;
                res_next.char_count      = 3'd4;
                res_next.last            = 1'b0;
                res_next.octets_consumed = '0;
                res_next.error           = dnd_pkg::ERR_NONE;
                res_valid_next           = 1'b1;
                pack_next                = '0;
                fill_next                = '0;
            end
            else
            begin
                pack_next = pack_reg | placed;
                fill_next = fill_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_reg      <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pack_reg      <= pack_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload carries no reset.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- hdl/dnd_walker.sv -----
// ----------------------------------------------------------------------------
// dnd_walker
// Sequencer that walks a name through the message memory, one byte at a time.
// ----------------------------------------------------------------------------
module dnd_walker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  dnd_pkg::dnd_in_t            cmd,
    output logic                        ram_we,
    output logic [dnd_pkg::ADDR_W-1:0]  ram_waddr,
    output logic [7:0]                  ram_wdata,
    output logic [dnd_pkg::ADDR_W-1:0]  ram_raddr,
    input  logic [7:0]                  ram_rdata,
    output dnd_pkg::dnd_push_t          push,
    input  logic                        push_ready
);

    dnd_pkg::dnd_state_t        state_reg, state_next;
    logic [dnd_pkg::ADDR_W-1:0] rp_reg, rp_next;
    logic [5:0]                 lr_reg, lr_next;
    logic [4:0]                 hop_reg, hop_next;
    logic [7:0]                 nlen_reg, nlen_next;
    logic [8:0]                 cc_reg, cc_next;
    logic                       ps_reg, ps_next;
    logic [5:0]                 hi_reg, hi_next;
    dnd_pkg::dnd_err_t          err_reg, err_next;

    logic       start;
    logic       is_zero;
    logic       is_ptr;
    logic       hop_over;
    logic       too_long;
    logic [9:0] wire_len;
    logic [5:0] lr_new;

    // Decode of the byte at the read pointer.
    assign start    = cmd_valid && (state_reg == dnd_pkg::ST_IDLE)
                      && (cmd.mode == dnd_pkg::MODE_DECODE);
    assign is_zero  = (ram_rdata == 8'd0);
    assign is_ptr   = (ram_rdata[7:6] == 2'b11);
    assign lr_new   = ram_rdata[5:0];
    assign hop_over = (hop_reg >= 5'(dnd_pkg::MAX_HOPS));
    assign wire_len = {2'b00, nlen_reg} + {4'd0, lr_new} + 10'd2;
    assign too_long = (wire_len > 10'(dnd_pkg::MAX_NAME_LENGTH));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dnd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = dnd_pkg::ST_LEN;
                end
            end
            dnd_pkg::ST_LEN:
            begin
                priority if (is_zero)
                    state_next = dnd_pkg::ST_FIN;
                else if (is_ptr)
                    state_next = hop_over ? dnd_pkg::ST_FIN : dnd_pkg::ST_PTR;
                else if (too_long)
                    state_next = dnd_pkg::ST_FIN;
                else if (nlen_reg != 8'd0)
                    state_next = dnd_pkg::ST_DOT;
                else if (lr_new != 6'd0)
                    state_next = dnd_pkg::ST_CHR;
                else
                    state_next = dnd_pkg::ST_LEN;
            end
            dnd_pkg::ST_PTR:
            begin
                state_next = dnd_pkg::ST_LEN;
            end
            dnd_pkg::ST_DOT:
            begin
                if (push_ready)
                begin
                    state_next = (lr_reg != 6'd0) ? dnd_pkg::ST_CHR : dnd_pkg::ST_LEN;
                end
            end
            dnd_pkg::ST_CHR:
            begin
                if (push_ready && (lr_reg == 6'd1))
                begin
                    state_next = dnd_pkg::ST_LEN;
                end
            end
            dnd_pkg::ST_FIN:
            begin
                if (push_ready)
                begin
                    state_next = dnd_pkg::ST_IDLE;
                end
            end
            default: state_next = dnd_pkg::ST_IDLE;
        endcase
    end

    // Working registers of the walk.
    always_comb
    begin
        rp_next   = rp_reg;
        lr_next   = lr_reg;
        hop_next  = hop_reg;
        nlen_next = nlen_reg;
        cc_next   = cc_reg;
        ps_next   = ps_reg;
        hi_next   = hi_reg;
        err_next  = err_reg;
        unique case (state_reg)
            dnd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    rp_next   = dnd_pkg::ADDR_W'(cmd.address);
                    lr_next   = '0;
                    hop_next  = '0;
                    nlen_next = '0;
                    cc_next   = '0;
                    ps_next   = 1'b0;
                    err_next  = dnd_pkg::ERR_NONE;
                end
            end
            dnd_pkg::ST_LEN:
            begin
                priority if (is_zero)
                begin
                    nlen_next = nlen_reg + 8'd1;
                    if (!ps_reg)
                    begin
                        cc_next = {1'b0, nlen_reg} + 9'd1;
                    end
                end
                else if (is_ptr)
                begin
                    if (hop_over)
                    begin
                        err_next = dnd_pkg::ERR_HOPS;
                    end
                    else
                    begin
                        hop_next = hop_reg + 5'd1;
                        hi_next  = ram_rdata[5:0];
                        rp_next  = rp_reg + dnd_pkg::ADDR_W'(1);
                        if (!ps_reg)
                        begin
                            cc_next = {1'b0, nlen_reg} + 9'd2;
                            ps_next = 1'b1;
                        end
                    end
                end
                else if (too_long)
                begin
                    err_next = dnd_pkg::ERR_LONG;
                end
                else
                begin
                    lr_next   = lr_new;
                    nlen_next = nlen_reg + {2'b00, lr_new} + 8'd1;
                    rp_next   = rp_reg + dnd_pkg::ADDR_W'(1);
                end
            end
            dnd_pkg::ST_PTR:
            begin
                // The pointer's low byte completes a 14-bit offset, cut to the address width.
                rp_next = dnd_pkg::ADDR_W'({hi_reg, ram_rdata});
            end
            dnd_pkg::ST_DOT:
            begin
                rp_next = rp_reg;
            end
            dnd_pkg::ST_CHR:
            begin
                if (push_ready)
                begin
                    rp_next = rp_reg + dnd_pkg::ADDR_W'(1);
                    lr_next = lr_reg - 6'd1;
                end
            end
            dnd_pkg::ST_FIN:
            begin
                rp_next = rp_reg;
            end
            default: rp_next = rp_reg;
        endcase
    end

    // Outputs: memory ports, input handshake and packer requests.
    always_comb
    begin
        cmd_ready   = (state_reg == dnd_pkg::ST_IDLE);
        ram_we      = cmd_valid && (state_reg == dnd_pkg::ST_IDLE)
                      && (cmd.mode == dnd_pkg::MODE_LOAD);
        ram_waddr   = dnd_pkg::ADDR_W'(cmd.address);
        ram_wdata   = cmd.data_byte;
        // Reading at the next pointer keeps the read data aligned to rp_reg.
        ram_raddr   = rp_next;
        push.push   = (state_reg == dnd_pkg::ST_DOT) || (state_reg == dnd_pkg::ST_CHR)
                      || (state_reg == dnd_pkg::ST_FIN);
        push.fin    = (state_reg == dnd_pkg::ST_FIN);
        push.ch     = (state_reg == dnd_pkg::ST_DOT) ? dnd_pkg::DOT_CHAR : ram_rdata;
        push.octets = (err_reg == dnd_pkg::ERR_NONE) ? cc_reg : 9'd0;
        push.err    = err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dnd_pkg::ST_IDLE;
            rp_reg    <= '0;
            lr_reg    <= '0;
            hop_reg   <= '0;
            nlen_reg  <= '0;
            cc_reg    <= '0;
            ps_reg    <= 1'b0;
            hi_reg    <= '0;
            err_reg   <= dnd_pkg::ERR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            lr_reg    <= lr_next;
            hop_reg   <= hop_next;
            nlen_reg  <= nlen_next;
            cc_reg    <= cc_next;
            ps_reg    <= ps_next;
            hi_reg    <= hi_next;
            err_reg   <= err_next;
        end
    end

endmodule
